### rtl/hpq_pkg.sv
// Shared types, constants and helper functions for the binary heap priority queue.
// Used by hpq_cell and binary_heap_priority_queue; depends on nothing else.

package hpq_pkg;

	// Key and entry count widths.
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 7;
	localparam int CAPACITY = 127;

	// Level numbering: level 0 is the root, level k holds 2**k slots.
	localparam int LVL_W     = 3;
	localparam int NUM_CELLS = 6;
	// Each cell stores its level as rows of sibling pairs.
	localparam int ROWS  = 32;
	localparam int ROW_W = 5;

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} hpq_cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} hpq_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_UP,
		ST_DOWN,
		ST_RESULT
	} hpq_state_t;

	// Access request from the sequencer to one level cell.
	typedef struct packed {
		logic             rd_en;
		logic [ROW_W-1:0] rd_row;
		logic             wr_lo;
		logic             wr_hi;
		logic [ROW_W-1:0] wr_row;
		logic [KEY_W-1:0] wr_key;
	} hpq_cell_req_t;

	// What a cell returns from its registered pair.
	typedef struct packed {
		logic [KEY_W-1:0] sel_key;
		logic [KEY_W-1:0] best_key;
		logic             best_side;
	} hpq_cell_rsp_t;

	// True when key a belongs above key b under the chosen order.
	function automatic logic above(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
			input logic order);
		if (order)
			return $signed(a) < $signed(b);
		else
			return $signed(a) > $signed(b);
	endfunction

	// Level of a slot index: position of its leading one.
	function automatic logic [LVL_W-1:0] lvl_of(input logic [CNT_W-1:0] idx);
		logic [LVL_W-1:0] l;
		l = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (idx[i])
				l = LVL_W'(i);
		end
		return l;
	endfunction

	// Position of a slot within its level: the index with its leading one cleared.
	function automatic logic [CNT_W-2:0] slot_pos(input logic [CNT_W-1:0] idx,
			input logic [LVL_W-1:0] lvl);
		logic [CNT_W-1:0] p;
		p = idx & ~(CNT_W'(1) << lvl);
		return p[CNT_W-2:0];
	endfunction

	// Row of the sibling pair that holds a slot, within its level cell.
	function automatic logic [ROW_W-1:0] row_of(input logic [CNT_W-1:0] idx,
			input logic [LVL_W-1:0] lvl);
		logic [CNT_W-2:0] p;
		p = slot_pos(idx, lvl);
		return p[ROW_W:1];
	endfunction

	// Row that holds the two children of a slot, in the cell one level down.
	function automatic logic [ROW_W-1:0] child_row_of(input logic [CNT_W-1:0] idx,
			input logic [LVL_W-1:0] lvl);
		logic [CNT_W-2:0] p;
		p = slot_pos(idx, lvl);
		return p[ROW_W-1:0];
	endfunction

endpackage

### rtl/hpq_cell.sv
// One level of the heap: a memory of sibling pairs with a registered read port.
// Depends on hpq_pkg for the request and response types and the key order.

module hpq_cell
	import hpq_pkg::*;
(
	input  logic          clk,
	input  hpq_cell_req_t req,
	input  logic          side,
	input  logic          right_ok,
	input  logic          order,
	output hpq_cell_rsp_t rsp
);

	logic [KEY_W-1:0] mem_lo [ROWS];
	logic [KEY_W-1:0] mem_hi [ROWS];
	logic [KEY_W-1:0] rd_lo_q;
	logic [KEY_W-1:0] rd_hi_q;
	logic             pick_hi;

	// Writes go to one side of a pair.
	always_ff @(posedge clk) begin
		if (req.wr_lo)
			mem_lo[req.wr_row] <= req.wr_key;
		if (req.wr_hi)
			mem_hi[req.wr_row] <= req.wr_key;
	end

	// The whole pair is read at once and held until the next read.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_lo_q <= mem_lo[req.rd_row];
			rd_hi_q <= mem_hi[req.rd_row];
		end
	end

	// The right child wins only when it exists and is strictly better; ties go left.
	assign pick_hi = right_ok && above(rd_hi_q, rd_lo_q, order);

	always_comb begin
		rsp.sel_key   = side ? rd_hi_q : rd_lo_q;
		rsp.best_side = pick_hi;
		rsp.best_key  = pick_hi ? rd_hi_q : rd_lo_q;
	end

endmodule

### rtl/binary_heap_priority_queue.sv
// Binary heap priority queue of signed 32-bit keys, max- or min-ordered.
// Depends on hpq_pkg and on hpq_cell, one cell for each level below the root.
//
// Input channel: in_valid, in_stall, command, value. A beat is taken when
// in_valid is high and in_stall low. An insert places the key in the next free
// slot and sifts it up; a remove moves the last entry to the root and sifts down.
// Output channel: out_valid, out_stall, top_value, count, empty_res, status. Every
// input beat gives exactly one output beat with the root key (0 when empty), the
// entry count, the empty flag and a status (ok, remove on empty, insert on full).
// Configuration: cfg_we writes cfg_data into the order bit (0 largest key on top,
// 1 smallest key on top); write it only while the queue is idle.
// Flow: one item is worked at a time. An insert sifts up from its new slot toward
// the root; a remove fetches the last entry, then sifts down one level at a time
// while it walks the level cells; an item that changes nothing goes straight to
// the result. The registered read in each level cell sets the pace of one level
// per cycle. The result sits in an output register, so the next item is taken
// while it waits; when out_stall holds, a finished item waits there and the
// queue takes no further item until the register is free.
// Reset empties the queue and selects largest key on top; no clearing pass runs.

module binary_heap_priority_queue
	import hpq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    command,
	input  logic signed [KEY_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [KEY_W-1:0] top_value,
	output logic [CNT_W-1:0]        count,
	output logic                    empty_res,
	output logic [1:0]              status
);

	hpq_state_t        state_q, nxt_state;
	logic              order_q;
	logic [CNT_W-1:0]  count_q, nxt_count;
	hpq_status_t       status_q, nxt_status;
	logic [KEY_W-1:0]  root_q;
	logic [KEY_W-1:0]  carry_q, nxt_carry;
	logic [CNT_W-1:0]  idx_q, nxt_idx;
	logic [CNT_W-1:0]  child_q, nxt_child;
	logic [LVL_W-1:0]  lvl_q, nxt_lvl;

	logic              out_valid_q;
	logic [KEY_W-1:0]  top_q;
	logic [CNT_W-1:0]  count_out_q;
	logic              empty_q;
	hpq_status_t       status_out_q;

	// Sequencer requests, fanned out to the cells below.
	logic              root_we;
	logic [KEY_W-1:0]  root_d;
	logic              wr_go;
	logic [LVL_W-1:0]  wr_lvl;
	logic [CNT_W-1:0]  wr_slot;
	logic [KEY_W-1:0]  wr_key;
	logic              rd_go;
	logic [LVL_W-1:0]  rd_lvl;
	logic [ROW_W-1:0]  rd_row;
	logic              load_out;

	logic [CNT_W-1:0]  new_slot;
	logic [LVL_W-1:0]  new_lvl;
	logic [CNT_W-1:0]  up_idx;
	logic [CNT_W-1:0]  down_idx;
	logic [CNT_W:0]    left_slot;
	logic [CNT_W:0]    count_ext;
	logic              left_ok;
	logic              right_ok;
	logic [KEY_W-1:0]  node_key;
	logic [KEY_W-1:0]  up_node;
	hpq_cell_rsp_t     kid;

	hpq_cell_req_t     cell_req [NUM_CELLS];
	hpq_cell_rsp_t     cell_rsp [NUM_CELLS];

	// One cell per level below the root; cell c holds level c + 1.
	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		hpq_cell u_cell (
			.clk      (clk),
			.req      (cell_req[c]),
			.side     (idx_q[0]),
			.right_ok (right_ok),
			.order    (order_q),
			.rsp      (cell_rsp[c])
		);
	end

	// Path arithmetic for the current step.
	assign new_slot  = count_q + CNT_W'(1);
	assign new_lvl   = lvl_of(new_slot);
	assign up_idx    = idx_q >> 1;
	assign left_slot = {idx_q, 1'b0};
	assign count_ext = {1'b0, count_q};
	assign left_ok   = left_slot <= count_ext;
	assign right_ok  = left_slot < count_ext;
	assign down_idx  = {idx_q[CNT_W-2:0], kid.best_side};

	// Pick the node entry from the cell at the current level and the children
	// from the cell one level below.
	always_comb begin
		node_key = cell_rsp[0].sel_key;
		kid      = cell_rsp[0];
		for (int c = 0; c < NUM_CELLS; c++) begin
			if (LVL_W'(c + 1) == lvl_q)
				node_key = cell_rsp[c].sel_key;
			if (LVL_W'(c) == lvl_q)
				kid = cell_rsp[c];
		end
	end

	assign up_node = (lvl_q == '0) ? root_q : node_key;

	// Sequencer: next state and the reads and writes of this cycle.
	always_comb begin
		nxt_state  = state_q;
		nxt_count  = count_q;
		nxt_status = status_q;
		nxt_carry  = carry_q;
		nxt_idx    = idx_q;
		nxt_child  = child_q;
		nxt_lvl    = lvl_q;
		root_we    = 1'b0;
		root_d     = carry_q;
		wr_go      = 1'b0;
		wr_lvl     = lvl_q;
		wr_slot    = idx_q;
		wr_key     = carry_q;
		rd_go      = 1'b0;
		rd_lvl     = lvl_q;
		rd_row     = '0;
		load_out   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					nxt_status = STAT_OK;
					if (command == CMD_INSERT) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							nxt_status = STAT_FULL;
							nxt_state  = ST_RESULT;
						end else if (new_lvl == '0) begin
							// First entry goes straight to the root.
							nxt_count = new_slot;
							root_we   = 1'b1;
							root_d    = value;
							nxt_state = ST_RESULT;
						end else begin
							nxt_count = new_slot;
							nxt_carry = value;
							nxt_idx   = new_slot >> 1;
							nxt_child = new_slot;
							nxt_lvl   = new_lvl - LVL_W'(1);
							rd_go     = 1'b1;
							rd_lvl    = new_lvl - LVL_W'(1);
							rd_row    = row_of(new_slot >> 1, new_lvl - LVL_W'(1));
							nxt_state = ST_UP;
						end
					end else begin
						if (count_q == '0) begin
							nxt_status = STAT_EMPTY;
							nxt_state  = ST_RESULT;
						end else if (count_q == CNT_W'(1)) begin
							nxt_count = '0;
							nxt_state = ST_RESULT;
						end else begin
							// Fetch the last entry before it moves to the root.
							nxt_count = count_q - CNT_W'(1);
							nxt_idx   = count_q;
							nxt_lvl   = lvl_of(count_q);
							rd_go     = 1'b1;
							rd_lvl    = lvl_of(count_q);
							rd_row    = row_of(count_q, lvl_of(count_q));
							nxt_state = ST_FETCH;
						end
					end
				end
			end

			ST_FETCH: begin
				nxt_carry = node_key;
				nxt_idx   = CNT_W'(1);
				nxt_lvl   = '0;
				rd_go     = 1'b1;
				rd_lvl    = LVL_W'(1);
				rd_row    = '0;
				nxt_state = ST_DOWN;
			end

			ST_UP: begin
				wr_go   = 1'b1;
				wr_lvl  = lvl_q + LVL_W'(1);
				wr_slot = child_q;
				if (above(carry_q, up_node, order_q)) begin
					// The node moves down one level and the key climbs on.
					wr_key = up_node;
					if (lvl_q == '0) begin
						root_we   = 1'b1;
						root_d    = carry_q;
						nxt_state = ST_RESULT;
					end else begin
						nxt_idx   = up_idx;
						nxt_child = idx_q;
						nxt_lvl   = lvl_q - LVL_W'(1);
						rd_go     = 1'b1;
						rd_lvl    = lvl_q - LVL_W'(1);
						rd_row    = row_of(up_idx, lvl_q - LVL_W'(1));
					end
				end else begin
					wr_key    = carry_q;
					nxt_state = ST_RESULT;
				end
			end

			ST_DOWN: begin
				if (left_ok && above(kid.best_key, carry_q, order_q)) begin
					// The better child moves up into the current slot.
					if (lvl_q == '0) begin
						root_we = 1'b1;
						root_d  = kid.best_key;
					end else begin
						wr_go  = 1'b1;
						wr_key = kid.best_key;
					end
					nxt_idx = down_idx;
					nxt_lvl = lvl_q + LVL_W'(1);
					rd_go   = 1'b1;
					rd_lvl  = lvl_q + LVL_W'(2);
					rd_row  = child_row_of(down_idx, lvl_q + LVL_W'(1));
				end else begin
					if (lvl_q == '0) begin
						root_we = 1'b1;
						root_d  = carry_q;
					end else begin
						wr_go  = 1'b1;
						wr_key = carry_q;
					end
					nxt_state = ST_RESULT;
				end
			end

			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					load_out  = 1'b1;
					nxt_state = ST_IDLE;
				end
			end

			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	// Fan the sequencer's read and write out to the addressed cell.
	always_comb begin
		for (int c = 0; c < NUM_CELLS; c++) begin
			cell_req[c].rd_en  = rd_go && (rd_lvl == LVL_W'(c + 1));
			cell_req[c].rd_row = rd_row;
			cell_req[c].wr_lo  = wr_go && (wr_lvl == LVL_W'(c + 1)) && !wr_slot[0];
			cell_req[c].wr_hi  = wr_go && (wr_lvl == LVL_W'(c + 1)) && wr_slot[0];
			cell_req[c].wr_row = row_of(wr_slot, wr_lvl);
			cell_req[c].wr_key = wr_key;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			order_q  <= 1'b0;
			count_q  <= '0;
			status_q <= STAT_OK;
		end else begin
			state_q  <= nxt_state;
			count_q  <= nxt_count;
			status_q <= nxt_status;
			if (cfg_we)
				order_q <= cfg_data;
		end
	end

	// Working registers of the sift.
	always_ff @(posedge clk) begin
		carry_q <= nxt_carry;
		idx_q   <= nxt_idx;
		child_q <= nxt_child;
		lvl_q   <= nxt_lvl;
		if (root_we)
			root_q <= root_d;
	end

	// Output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			top_q        <= (count_q != '0) ? root_q : '0;
			count_out_q  <= count_q;
			empty_q      <= (count_q == '0);
			status_out_q <= status_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign top_value = top_q;
	assign count     = count_out_q;
	assign empty_res = empty_q;
	assign status    = status_out_q;

endmodule
